// ----- src/per_cpu_page_free_list_allocator_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the per-processor page allocator.
// Each macro places one labeled concurrent assertion.
// ----------------------------------------------------------------------------
`ifndef PER_CPU_PAGE_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define PER_CPU_PAGE_FREE_LIST_ALLOCATOR_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define PCPA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequent holds in the cycle after the antecedent.
`define PCPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- src/pcpa_pkg.sv -----
// ----------------------------------------------------------------------------
// pcpa_pkg
// Shared constants, types and helpers of the per-processor page allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pcpa_pkg;

	localparam int NUM_CPUS  = 8;
	localparam int NUM_PAGES = 32768;

	localparam int ADDR_W     = 40;
	localparam int CPU_W      = 3;
	localparam int IDX_W      = 16;
	localparam int PAGE_SHIFT = 12;
	localparam int PAGE_NUM_W = ADDR_W - PAGE_SHIFT + 1;
	localparam int CPU_IW     = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
	localparam int LINK_AW    = $clog2(NUM_PAGES);
	localparam int CFG_IDX_W  = 1;

	localparam logic [IDX_W-1:0] EMPTY_MARK = '1;

	localparam logic [ADDR_W-1:0] LOW_LIMIT_RST = 40'h00_8000_0000;
	localparam logic [ADDR_W-1:0] TOP_LIMIT_RST = 40'h00_8800_0000;

	localparam logic [CFG_IDX_W-1:0] CFG_LOW_LIMIT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_TOP_LIMIT = 1'b1;

	localparam logic OP_FREE  = 1'b0;
	localparam logic OP_ALLOC = 1'b1;

	localparam logic [1:0] ST_ALLOCATED = 2'd0;
	localparam logic [1:0] ST_FREED     = 2'd1;
	localparam logic [1:0] ST_NO_PAGE   = 2'd2;
	localparam logic [1:0] ST_BAD_FREE  = 2'd3;

	typedef struct packed {
		logic              operation;
		logic [CPU_W-1:0]  cpu;
		logic [ADDR_W-1:0] page_address;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0] result_address;
		logic [1:0]        status;
	} rsp_t;

	typedef struct packed {
		logic [ADDR_W-1:0]     low_limit;
		logic [ADDR_W-1:0]     top_limit;
		logic [PAGE_NUM_W-1:0] base_page;
	} limits_t;

	// Rounds the low limit up to the next page and returns its page number.
	function automatic logic [PAGE_NUM_W-1:0] base_page_of(input logic [ADDR_W-1:0] low);
		logic [PAGE_NUM_W-1:0] pn;
		pn = {1'b0, low[ADDR_W-1:PAGE_SHIFT]};
		return pn + PAGE_NUM_W'(low[PAGE_SHIFT-1:0] != '0);
	endfunction

	// Folds a processor number into the range of processors.
	function automatic logic [CPU_IW-1:0] cpu_wrap(input logic [CPU_W-1:0] c);
		logic [CPU_W:0] v;
		v = {1'b0, c};
		for (int i = 0; i < (1 << CPU_W) - 1; i++) begin
			if (v >= (CPU_W + 1)'(NUM_CPUS)) begin
				v = v - (CPU_W + 1)'(NUM_CPUS);
			end
		end
		return CPU_IW'(v);
	endfunction

endpackage

// ----- src/per_cpu_page_free_list_allocator.sv -----
// A free passes through the check and push states before its result shows; an
// allocate scans the list heads from the requester's own onward and pops from
// the first list that holds a page, or reports no page when every list is empty.
// One item at a time; the next item is taken in the cycle its result shows.
// The head scan, one list head per cycle, bounds the allocate time.
// Reset empties every list at once; the link memory needs no clearing.
// ----------------------------------------------------------------------------
// per_cpu_page_free_list_allocator
// Per-processor LIFO page free lists with stealing from other processors.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "per_cpu_page_free_list_allocator_defines.svh"

module per_cpu_page_free_list_allocator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  pcpa_pkg::req_t                 req,
	output logic                           done,
	output pcpa_pkg::rsp_t                 rsp,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [pcpa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pcpa_pkg::ADDR_W-1:0]    cfg_data
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_PUSH,
		S_SCAN,
		S_POP
	} state_t;

	state_t                          state_q;
	pcpa_pkg::limits_t               limits;
	logic [pcpa_pkg::ADDR_W-1:0]     addr_q;
	logic [pcpa_pkg::CPU_IW-1:0]     scan_q;
	logic [pcpa_pkg::CPU_IW-1:0]     count_q;
	logic                            bad_q;
	logic [pcpa_pkg::LINK_AW-1:0]    idx_q;
	logic [pcpa_pkg::LINK_AW-1:0]    page_q;
	logic [pcpa_pkg::IDX_W-1:0]      heads_q [pcpa_pkg::NUM_CPUS];
	logic                            done_q;
	pcpa_pkg::rsp_t                  rsp_q;

	logic [pcpa_pkg::IDX_W-1:0]      head;
	logic                            head_ok;
	logic [pcpa_pkg::CPU_IW-1:0]     scan_next;
	logic [pcpa_pkg::PAGE_NUM_W-1:0] addr_page;
	logic [pcpa_pkg::PAGE_NUM_W-1:0] page_diff;
	logic                            bad_free;
	logic [pcpa_pkg::PAGE_NUM_W-1:0] out_page;
	logic                            ram_we;
	logic                            ram_re;
	logic [pcpa_pkg::IDX_W-1:0]      ram_rdata;

	pcpa_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.limits    (limits)
	);

	pcpa_link_ram u_link_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_q),
		.wdata (head),
		.re    (ram_re),
		.raddr (head[pcpa_pkg::LINK_AW-1:0]),
		.rdata (ram_rdata)
	);

	assign head      = heads_q[scan_q];
	assign head_ok   = (head != pcpa_pkg::EMPTY_MARK) &&
	                   (head < pcpa_pkg::IDX_W'(pcpa_pkg::NUM_PAGES));
	assign scan_next = (scan_q == pcpa_pkg::CPU_IW'(pcpa_pkg::NUM_CPUS - 1)) ?
	                   '0 : scan_q + 1'b1;

	assign addr_page = {1'b0, addr_q[pcpa_pkg::ADDR_W-1:pcpa_pkg::PAGE_SHIFT]};
	assign page_diff = addr_page - limits.base_page;
	assign bad_free  = (addr_q[pcpa_pkg::PAGE_SHIFT-1:0] != '0) ||
	                   (addr_q < limits.low_limit) ||
	                   (addr_q >= limits.top_limit) ||
	                   (addr_page < limits.base_page) ||
	                   (page_diff >= pcpa_pkg::PAGE_NUM_W'(pcpa_pkg::NUM_PAGES));

	assign out_page = limits.base_page + pcpa_pkg::PAGE_NUM_W'(page_q);

	assign ram_we = (state_q == S_PUSH) && !bad_q;
	assign ram_re = (state_q == S_SCAN) && head_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			scan_q  <= '0;
			count_q <= '0;
			bad_q   <= 1'b0;
			for (int i = 0; i < pcpa_pkg::NUM_CPUS; i++) begin
				heads_q[i] <= pcpa_pkg::EMPTY_MARK;
			end
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						addr_q  <= req.page_address;
						scan_q  <= pcpa_pkg::cpu_wrap(req.cpu);
						count_q <= '0;
						state_q <= (req.operation == pcpa_pkg::OP_ALLOC) ? S_SCAN : S_CHECK;
					end
				end
				S_CHECK: begin
					bad_q   <= bad_free;
					idx_q   <= page_diff[pcpa_pkg::LINK_AW-1:0];
					state_q <= S_PUSH;
				end
				S_PUSH: begin
					rsp_q.result_address <= '0;
					if (bad_q) begin
						rsp_q.status <= pcpa_pkg::ST_BAD_FREE;
					end else begin
						heads_q[scan_q] <= pcpa_pkg::IDX_W'(idx_q);
						rsp_q.status    <= pcpa_pkg::ST_FREED;
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_SCAN: begin
					if (head_ok) begin
						page_q  <= head[pcpa_pkg::LINK_AW-1:0];
						state_q <= S_POP;
					end else if (count_q == pcpa_pkg::CPU_IW'(pcpa_pkg::NUM_CPUS - 1)) begin
						rsp_q.result_address <= '0;
						rsp_q.status         <= pcpa_pkg::ST_NO_PAGE;
						done_q               <= 1'b1;
						state_q              <= S_IDLE;
					end else begin
						count_q <= count_q + 1'b1;
						scan_q  <= scan_next;
					end
				end
				S_POP: begin
					heads_q[scan_q]      <= ram_rdata;
					rsp_q.result_address <= {out_page[pcpa_pkg::ADDR_W-pcpa_pkg::PAGE_SHIFT-1:0],
					                         {pcpa_pkg::PAGE_SHIFT{1'b0}}};
					rsp_q.status         <= pcpa_pkg::ST_ALLOCATED;
					done_q               <= 1'b1;
					state_q              <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	`PCPA_ASSERT_SAME(a_done_idle, clk, arst_n, done, !busy)
	`PCPA_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy && !done)
	`PCPA_ASSERT_SAME(a_zero_addr, clk, arst_n,
		done && (rsp.status != pcpa_pkg::ST_ALLOCATED), rsp.result_address == '0)
	`PCPA_ASSERT_SAME(a_ram_ports, clk, arst_n, ram_we, !ram_re)

endmodule

// ----- src/pcpa_link_ram.sv -----
// ----------------------------------------------------------------------------
// pcpa_link_ram
// Next-page link memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcpa_link_ram (
	input  logic                         clk,
	input  logic                         we,
	input  logic [pcpa_pkg::LINK_AW-1:0] waddr,
	input  logic [pcpa_pkg::IDX_W-1:0]   wdata,
	input  logic                         re,
	input  logic [pcpa_pkg::LINK_AW-1:0] raddr,
	output logic [pcpa_pkg::IDX_W-1:0]   rdata
);

	logic [pcpa_pkg::IDX_W-1:0] mem [pcpa_pkg::NUM_PAGES];
	logic [pcpa_pkg::IDX_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- src/pcpa_cfg.sv -----
// ----------------------------------------------------------------------------
// pcpa_cfg
// Limit registers and the derived page base.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcpa_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [pcpa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pcpa_pkg::ADDR_W-1:0]    cfg_data,
	output pcpa_pkg::limits_t              limits
);

	pcpa_pkg::limits_t limits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q.low_limit <= pcpa_pkg::LOW_LIMIT_RST;
			limits_q.top_limit <= pcpa_pkg::TOP_LIMIT_RST;
			limits_q.base_page <= pcpa_pkg::base_page_of(pcpa_pkg::LOW_LIMIT_RST);
		end else if (cfg_valid) begin
			case (cfg_index)
				pcpa_pkg::CFG_LOW_LIMIT: begin
					limits_q.low_limit <= cfg_data;
					limits_q.base_page <= pcpa_pkg::base_page_of(cfg_data);
				end
				pcpa_pkg::CFG_TOP_LIMIT: begin
					limits_q.top_limit <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg_ready = 1'b1;
	assign limits    = limits_q;

endmodule
